/* rtl/tccw_pkg.sv */
// Package for the text console writer: codes, field widths and sequencer states.
package tccw_pkg;

	// Result field widths
	localparam int COL_W = 7;
	localparam int ROW_W = 5;
	localparam int LOC_W = 11;

	// Cell layout: attribute byte over character byte
	localparam int CELL_W = 16;
	localparam int COLOR_W = 4;

	// Request codes
	localparam logic REQ_PUT   = 1'b0;
	localparam logic REQ_CLEAR = 1'b1;

	// Configuration register indexes
	localparam logic REG_FG = 1'b0;
	localparam logic REG_BG = 1'b1;

	// Reset colors
	localparam logic [COLOR_W-1:0] FG_RESET = 4'h4;
	localparam logic [COLOR_W-1:0] BG_RESET = 4'h0;

	// Character codes
	localparam logic [7:0] CH_BS       = 8'h08;
	localparam logic [7:0] CH_TAB      = 8'h09;
	localparam logic [7:0] CH_LF       = 8'h0A;
	localparam logic [7:0] CH_CR       = 8'h0D;
	localparam logic [7:0] CH_BLANK    = 8'h20;
	localparam logic [7:0] CH_PRINT_LO = 8'h20;
	localparam logic [7:0] CH_PRINT_HI = 8'h7F;

	// Memory sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCROLL,
		ST_FILL
	} state_t;

endpackage

/* rtl/text_console_char_writer.sv */
// Text console writer: cursor logic and screen cell memory with scroll and fill sequencer.
//
// Usage:
// - Input channel (in_valid/in_ready) takes one word: req_type (put byte or clear screen)
//   and char_code. Output channel (out_valid/out_ready) returns one word per input word:
//   cursor column, row, linear location and a scroll flag.
// - Config channel (cfg_valid/cfg_ready) writes fg_color (index 0) or bg_color (index 1);
//   it is always ready. The blank attribute for a scroll or clear is captured when the
//   request is taken, so a later color write does not disturb a running sweep.
// - Result: the result is registered on the output in the cycle after the input is taken,
//   also for scroll and clear; the memory sweep then runs on behind it.
// - Sweeps: a printable byte without scroll is written through the single write port
//   of the cell memory. A scroll copies each row into the row above, then fills the
//   bottom row with blanks; a clear fills every cell. No input is taken meanwhile.
// - Reset: cursor goes to the top left, colors to fg 4 / bg 0, and a clearing pass
//   writes zero to every cell before the first input is taken.
// - Stall: the output register holds a result until out_ready; the next input is taken
//   in the same cycle the held result leaves, if no sweep is running.
module text_console_char_writer #(
	parameter int COLUMNS   = 80,
	parameter int ROWS      = 25,
	parameter int TAB_WIDTH = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// request channel
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         req_type,
	input  logic [7:0]                   char_code,
	// result channel
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [tccw_pkg::COL_W-1:0]   cursor_col,
	output logic [tccw_pkg::ROW_W-1:0]   cursor_row,
	output logic [tccw_pkg::LOC_W-1:0]   cursor_location,
	output logic                         did_scroll,
	// config channel
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic                         cfg_index,
	input  logic [tccw_pkg::COLOR_W-1:0] cfg_data
);

	import tccw_pkg::*;

	localparam int CELLS = COLUMNS * ROWS;
	localparam int AW    = $clog2(CELLS);
	localparam int PW    = $clog2(CELLS + 1);
	localparam int CW    = $clog2(COLUMNS);
	localparam int RW    = $clog2(ROWS);
	localparam int XW    = $clog2(COLUMNS + TAB_WIDTH + 1);
	localparam int RXW   = $clog2(ROWS + 1);
	localparam int TW    = $clog2(TAB_WIDTH);

	// Cell memory
	logic [CELL_W-1:0] screen_mem [CELLS];

	state_t state_q, state_d;
	logic [PW-1:0]      ptr_q;
	logic [CELL_W-1:0]  blank_q;
	logic [CW-1:0]      col_q;
	logic [RW-1:0]      row_q;
	logic [TW-1:0]      phase_q;
	logic [COLOR_W-1:0] fg_q, bg_q;

	logic               copy_s1;
	logic [AW-1:0]      copy_addr_s1;
	logic [CELL_W-1:0]  rdata_s1;

	logic               out_valid_q;
	logic [COL_W-1:0]   cursor_col_q;
	logic [ROW_W-1:0]   cursor_row_q;
	logic [LOC_W-1:0]   cursor_loc_q;
	logic               did_scroll_q;

	logic               in_fire, cfg_fire;
	logic [XW-1:0]      n_col;
	logic [RXW-1:0]     n_row;
	logic [TW-1:0]      n_phase;
	logic               n_scroll, put_wr;
	logic [PW-1:0]      cur_addr;
	logic [PW+LOC_W-1:0] loc_ext;
	logic [7:0]         attr;

	logic               mem_we, mem_re;
	logic [AW-1:0]      mem_wa, mem_ra;
	logic [CELL_W-1:0]  mem_wd;

	assign in_ready  = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign in_fire   = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid;
	assign attr      = {bg_q, fg_q};

	// Next cursor for a put request; a clear leaves it alone
	always_comb begin
		n_col   = XW'(col_q);
		n_row   = RXW'(row_q);
		n_phase = phase_q;
		put_wr  = 1'b0;
		if (req_type == REQ_PUT) begin
			case (char_code)
				CH_BS: begin
					if (col_q != '0) begin
						n_col   = XW'(col_q) - XW'(1);
						n_phase = (phase_q == '0) ? TW'(TAB_WIDTH - 1) : phase_q - TW'(1);
					end
				end
				CH_TAB: begin
					n_col   = XW'(col_q) - XW'(phase_q) + XW'(TAB_WIDTH);
					n_phase = '0;
				end
				CH_CR: begin
					n_col   = '0;
					n_phase = '0;
				end
				CH_LF: begin
					n_col   = '0;
					n_phase = '0;
					n_row   = RXW'(row_q) + RXW'(1);
				end
				default: begin
					if (char_code >= CH_PRINT_LO && char_code <= CH_PRINT_HI) begin
						put_wr  = 1'b1;
						n_col   = XW'(col_q) + XW'(1);
						n_phase = (phase_q == TW'(TAB_WIDTH - 1)) ? '0 : phase_q + TW'(1);
					end
				end
			endcase
			// wrap past last column
			if (n_col >= XW'(COLUMNS)) begin
				n_col   = '0;
				n_phase = '0;
				n_row   = n_row + RXW'(1);
			end
		end
		n_scroll = (n_row >= RXW'(ROWS));
		if (n_scroll) begin
			n_row = RXW'(ROWS - 1);
		end
	end

	// Cell index of the cursor before and after the step
	assign cur_addr = PW'(row_q) * PW'(COLUMNS) + PW'(col_q);
	assign loc_ext  = (PW + LOC_W)'(n_row) * (PW + LOC_W)'(COLUMNS) + (PW + LOC_W)'(n_col);

	// Memory port selection: copy pipe, then sweep fill, then character put
	always_comb begin
		mem_we = 1'b0;
		mem_wa = '0;
		mem_wd = '0;
		if (copy_s1) begin
			mem_we = 1'b1;
			mem_wa = copy_addr_s1;
			mem_wd = rdata_s1;
		end else if (state_q == ST_FILL) begin
			mem_we = 1'b1;
			mem_wa = ptr_q[AW-1:0];
			mem_wd = blank_q;
		end else if (in_fire && put_wr) begin
			mem_we = 1'b1;
			mem_wa = cur_addr[AW-1:0];
			mem_wd = {attr, char_code};
		end
	end

	assign mem_re = (state_q == ST_SCROLL) && (ptr_q < PW'(CELLS));
	assign mem_ra = ptr_q[AW-1:0];

	always_ff @(posedge clk) begin
		if (mem_we) begin
			screen_mem[mem_wa] <= mem_wd;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_re) begin
			rdata_s1 <= screen_mem[mem_ra];
		end
	end

	// Sequencer next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					if (req_type == REQ_CLEAR) begin
						state_d = ST_FILL;
					end else if (n_scroll) begin
						state_d = ST_SCROLL;
					end
				end
			end
			ST_SCROLL: begin
				if (ptr_q == PW'(CELLS)) begin
					state_d = ST_FILL;
				end
			end
			ST_FILL: begin
				if (ptr_q == PW'(CELLS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Reset starts with a clearing pass that writes zero cells
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FILL;
		end else begin
			state_q <= state_d;
		end
	end

	// Sweep pointer, blank word and copy pipe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q        <= '0;
			blank_q      <= '0;
			copy_s1      <= 1'b0;
			copy_addr_s1 <= '0;
		end else begin
			copy_s1      <= mem_re;
			copy_addr_s1 <= AW'(ptr_q - PW'(COLUMNS));
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						blank_q <= {attr, CH_BLANK};
						ptr_q   <= (req_type == REQ_CLEAR) ? '0 : PW'(COLUMNS);
					end
				end
				ST_SCROLL: begin
					if (mem_re) begin
						ptr_q <= ptr_q + PW'(1);
					end else begin
						ptr_q <= PW'(CELLS - COLUMNS);
					end
				end
				ST_FILL: ptr_q <= ptr_q + PW'(1);
				default: ptr_q <= '0;
			endcase
		end
	end

	// Cursor and colors
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			phase_q <= '0;
			fg_q    <= FG_RESET;
			bg_q    <= BG_RESET;
		end else begin
			if (in_fire) begin
				col_q   <= CW'(n_col);
				row_q   <= RW'(n_row);
				phase_q <= n_phase;
			end
			if (cfg_fire) begin
				case (cfg_index)
					REG_FG:  fg_q <= cfg_data;
					REG_BG:  bg_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			cursor_col_q <= COL_W'(n_col);
			cursor_row_q <= ROW_W'(n_row);
			cursor_loc_q <= loc_ext[LOC_W-1:0];
			did_scroll_q <= n_scroll;
		end
	end

	assign out_valid       = out_valid_q;
	assign cursor_col      = cursor_col_q;
	assign cursor_row      = cursor_row_q;
	assign cursor_location = cursor_loc_q;
	assign did_scroll      = did_scroll_q;

`ifndef ASSERT_OFF
	// copy writes only follow reads issued by the scroll sweep
	a_copy_from_scroll: assert property (@(posedge clk) disable iff (!arst_n)
		copy_s1 |-> $past(state_q == ST_SCROLL))
		else $error("copy write without scroll read");

	// cursor stays on the screen
	a_cursor_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(col_q < CW'(COLUMNS - 1) || col_q == CW'(COLUMNS - 1)) &&
		(row_q < RW'(ROWS - 1) || row_q == RW'(ROWS - 1)))
		else $error("cursor off screen");

	// sweep pointer never runs past the cell count
	a_ptr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ptr_q <= PW'(CELLS))
		else $error("sweep pointer overrun");

	// a pending scroll result leaves the cursor on the bottom row
	a_scroll_bottom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && did_scroll_q |-> row_q == RW'(ROWS - 1))
		else $error("scroll without bottom row");

	// no input taken while the memory sweep is running
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCROLL || state_q == ST_FILL) |-> !in_ready)
		else $error("input accepted during sweep");
`endif

endmodule

/* tb/sv/console_cursor_check.sv */
// Cursor predictor and result comparison for the text console writer.
`timescale 1ns / 100ps

module console_cursor_check #(
	parameter int COLUMNS   = 80,
	parameter int ROWS      = 25,
	parameter int TAB_WIDTH = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// request channel
	input  logic                         in_valid,
	input  logic                         in_ready,
	input  logic                         req_type,
	input  logic [7:0]                   char_code,
	// result channel
	input  logic                         out_valid,
	input  logic                         out_ready,
	input  logic [tccw_pkg::COL_W-1:0]   cursor_col,
	input  logic [tccw_pkg::ROW_W-1:0]   cursor_row,
	input  logic [tccw_pkg::LOC_W-1:0]   cursor_location,
	input  logic                         did_scroll,
	// status to the test top
	output int                           errors,
	output int                           pending
);

	import tccw_pkg::*;

	typedef struct packed {
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic [LOC_W-1:0] loc;
		logic             scrolled;
	} cursor_word_t;

	// Only the cursor reaches the ports; cell contents and colors are not visible here
	int cur_col;
	int cur_row;
	cursor_word_t expected_cursor[$];

	// Move the cursor for one request and build the word it should report
	function automatic cursor_word_t step_cursor(input logic req, input logic [7:0] ch);
		int col;
		int row;
		int loc;
		logic rolled;
		cursor_word_t w;
		col = cur_col;
		row = cur_row;
		rolled = 1'b0;
		if (req == REQ_PUT) begin
			if (ch == CH_BS) begin
				if (col > 0)
					col = col - 1;
			end else if (ch == CH_TAB) begin
				col = (col / TAB_WIDTH) * TAB_WIDTH + TAB_WIDTH;
			end else if (ch == CH_CR) begin
				col = 0;
			end else if (ch == CH_LF) begin
				col = 0;
				row = row + 1;
			end else if (ch >= CH_PRINT_LO && ch <= CH_PRINT_HI) begin
				col = col + 1;
			end
			// wrap past the last column, scroll past the last row
			if (col >= COLUMNS) begin
				col = 0;
				row = row + 1;
			end
			if (row >= ROWS) begin
				row = ROWS - 1;
				rolled = 1'b1;
			end
		end
		// a clear leaves the cursor alone and never scrolls
		cur_col = col;
		cur_row = row;
		loc = row * COLUMNS + col;
		w.col = col[COL_W-1:0];
		w.row = row[ROW_W-1:0];
		w.loc = loc[LOC_W-1:0];
		w.scrolled = rolled;
		return w;
	endfunction

	function automatic void check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endfunction

	// Compare leaving words first, then predict the word just taken
	always @(posedge clk or negedge arst_n) begin : watch
		cursor_word_t want;
		if (!arst_n) begin
			cur_col = 0;
			cur_row = 0;
			errors = 0;
			expected_cursor.delete();
		end else begin
			if (out_valid && out_ready) begin
				if (expected_cursor.size() == 0) begin
					$error("result word with none expected: col %0d row %0d",
						cursor_col, cursor_row);
					errors++;
				end else begin
					want = expected_cursor.pop_front();
					check_field("cursor_col", want.col, cursor_col);
					check_field("cursor_row", want.row, cursor_row);
					check_field("cursor_location", want.loc, cursor_location);
					check_field("did_scroll", want.scrolled, did_scroll);
				end
			end
			if (in_valid && in_ready)
				expected_cursor.push_back(step_cursor(req_type, char_code));
		end
		pending = expected_cursor.size();
	end

endmodule

/* tb/sv/text_console_char_writer_test.sv */
// Test top for the text console writer: clock, reset, stimulus, result sink and verdict.
`timescale 1ns / 100ps

module text_console_char_writer_test;
	import tccw_pkg::*;

	localparam int COLUMNS   = 80;
	localparam int ROWS      = 25;
	localparam int TAB_WIDTH = 8;

	// a scroll or clear sweep outlasts its result; wait this long before a color write
	localparam int SWEEP_CYCLES    = COLUMNS * ROWS + COLUMNS + 16;
	localparam int CYCLE_LIMIT     = 4_000_000;
	localparam int HOLD_OFF_AT     = 160;
	localparam int HOLD_OFF_CYCLES = 400;

	typedef enum int {
		SINK_OPEN,
		SINK_COIN,
		SINK_SLOW,
		SINK_EVERY3
	} sink_mode_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic               req_type;
	logic [7:0]         char_code;
	logic               out_valid;
	logic               out_ready;
	logic [COL_W-1:0]   cursor_col;
	logic [ROW_W-1:0]   cursor_row;
	logic [LOC_W-1:0]   cursor_location;
	logic               did_scroll;
	logic               cfg_valid;
	logic               cfg_ready;
	logic               cfg_index;
	logic [COLOR_W-1:0] cfg_data;

	int failures;
	int pending;
	int burst_left;
	int words_sent;

	text_console_char_writer #(
		.COLUMNS(COLUMNS),
		.ROWS(ROWS),
		.TAB_WIDTH(TAB_WIDTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.req_type(req_type),
		.char_code(char_code),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.cursor_col(cursor_col),
		.cursor_row(cursor_row),
		.cursor_location(cursor_location),
		.did_scroll(did_scroll),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	console_cursor_check #(
		.COLUMNS(COLUMNS),
		.ROWS(ROWS),
		.TAB_WIDTH(TAB_WIDTH)
	) cursor_check (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.req_type(req_type),
		.char_code(char_code),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.cursor_col(cursor_col),
		.cursor_row(cursor_row),
		.cursor_location(cursor_location),
		.did_scroll(did_scroll),
		.errors(failures),
		.pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Run limit
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("text_console_char_writer_test failed");
		$finish;
	end

	// Result sink: changing stall modes, plus one long hold-off while requests keep coming
	initial begin : result_sink
		int taken;
		int mode_left;
		int phase;
		bit held;
		sink_mode_t mode;
		out_ready = 1'b0;
		taken = 0;
		mode_left = 0;
		phase = 0;
		held = 1'b0;
		mode = SINK_OPEN;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				taken++;
			@(negedge clk);
			if (!held && taken >= HOLD_OFF_AT) begin
				held = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
			end
			if (mode_left == 0) begin
				mode = sink_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(20, 200);
			end
			mode_left--;
			phase++;
			case (mode)
				SINK_OPEN: out_ready <= 1'b1;
				SINK_COIN: out_ready <= 1'($urandom_range(0, 1));
				SINK_SLOW: out_ready <= ($urandom_range(0, 3) == 0);
				default: out_ready <= (phase % 3 == 0);
			endcase
		end
	end

	// Lower valid and wait until every result word has come back
	task automatic wait_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	// Same, then let any scroll or clear sweep run out
	task automatic settle_block();
		wait_results();
		repeat (SWEEP_CYCLES) @(posedge clk);
	endtask

	// One request word, paced in bursts with gaps between them
	task automatic send_word(input logic req, input logic [7:0] ch);
		int gap;
		if (burst_left == 0) begin
			if ($urandom_range(0, 99) == 0)
				wait_results();
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 6);
			if (gap > 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
				: $urandom_range(1, 16);
		end
		burst_left--;
		@(negedge clk);
		in_valid <= 1'b1;
		req_type <= req;
		char_code <= ch;
		do
			@(posedge clk);
		while (!in_ready);
		words_sent++;
	endtask

	task automatic write_color(input logic idx, input logic [COLOR_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Terminal-like text: short lines ended by CR/LF, some long enough to wrap,
	// with stray cursor moves, raw bytes and an occasional clear mixed in
	task automatic send_text(input int count);
		int target;
		int pick;
		int len;
		target = words_sent + count;
		while (words_sent < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 60) begin
				len = ($urandom_range(0, 11) == 0) ? $urandom_range(70, 100)
					: $urandom_range(0, 8);
				// keep the last line inside the word budget
				if (len > target - words_sent)
					len = target - words_sent;
				repeat (len)
					send_word(REQ_PUT, 8'($urandom_range(CH_PRINT_LO, CH_PRINT_HI)));
				if ($urandom_range(0, 1))
					send_word(REQ_PUT, CH_CR);
				send_word(REQ_PUT, CH_LF);
			end else if (pick < 85) begin
				case ($urandom_range(0, 3))
					0: send_word(REQ_PUT, CH_BS);
					1: send_word(REQ_PUT, CH_TAB);
					2: send_word(REQ_PUT, CH_CR);
					default: send_word(REQ_PUT, CH_LF);
				endcase
			end else if (pick < 97) begin
				send_word(REQ_PUT, 8'($urandom));
			end else begin
				send_word(REQ_CLEAR, 8'($urandom));
			end
		end
	endtask

	initial begin : stimulus
		arst_n = 1'b0;
		in_valid = 1'b0;
		req_type = REQ_PUT;
		char_code = 8'h00;
		cfg_valid = 1'b0;
		cfg_index = REG_FG;
		cfg_data = '0;
		burst_left = 0;
		words_sent = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		write_color(REG_FG, 4'hF);
		write_color(REG_BG, 4'h0);

		// Directed: backspace at column 0, printable range ends, cursor moves,
		// ignored control and high bytes, a clear, then tabs until the line wraps
		send_word(REQ_PUT, CH_BS);
		send_word(REQ_PUT, 8'h41);
		send_word(REQ_PUT, CH_PRINT_HI);
		send_word(REQ_PUT, CH_BLANK);
		send_word(REQ_PUT, CH_BS);
		send_word(REQ_PUT, CH_TAB);
		send_word(REQ_PUT, CH_CR);
		send_word(REQ_PUT, CH_LF);
		send_word(REQ_PUT, 8'h00);
		send_word(REQ_PUT, 8'h1F);
		send_word(REQ_PUT, 8'h80);
		send_word(REQ_PUT, 8'hFF);
		send_word(REQ_CLEAR, 8'h41);
		repeat (COLUMNS / TAB_WIDTH) send_word(REQ_PUT, CH_TAB);
		settle_block();

		// Random text under several color settings
		write_color(REG_FG, 4'h0);
		write_color(REG_BG, 4'hF);
		send_text(110);
		settle_block();

		write_color(REG_FG, 4'($urandom));
		write_color(REG_BG, 4'($urandom));
		send_text(110);
		settle_block();

		write_color(REG_FG, 4'hF);
		write_color(REG_BG, 4'hF);
		send_text(110);
		settle_block();

		write_color(REG_FG, 4'h0);
		write_color(REG_BG, 4'h0);
		send_text(120);
		settle_block();

		if (failures == 0)
			$display("text_console_char_writer_test passed");
		else
			$display("text_console_char_writer_test failed");
		$finish;
	end

endmodule

/* sim.f */
rtl/tccw_pkg.sv
rtl/text_console_char_writer.sv
tb/sv/console_cursor_check.sv
tb/sv/text_console_char_writer_test.sv
